// ===== rtl/pph_pkg.sv =====
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types and codes for the parallel port byte handshake core.
// ----------------------------------------------------------------------------
package pph_pkg;

    localparam int CNT_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 4;
    localparam int CTL_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] INIT_PULSE_RST = 24'd100;

    // Request kinds
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Outcome codes
    localparam logic [1:0] OUT_OK       = 2'd0;
    localparam logic [1:0] OUT_WR_TMO   = 2'd1;
    localparam logic [1:0] OUT_RD_TMO   = 2'd2;
    localparam logic [1:0] OUT_REJECTED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_WRITE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_READ_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_INIT_PULSE  = 2'd2;

    // Control line bit positions
    localparam int CTL_STROBE = 0;
    localparam int CTL_AUTOFD = 1;
    localparam int CTL_INIT   = 2;

    // Handshake phases
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_W_FREE     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_W_BUSY     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_W_DONE     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_R_FREE     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_R_ACK      = 4'd5;
    localparam logic [PHASE_W-1:0] PH_R_REL      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RST_HOLD   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RST_SETTLE = 4'd8;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] send_byte;
        logic              new_transfer;
        logic              busy_seen;
        logic              ack_seen;
        logic [BYTE_W-1:0] port_lines;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] write_limit_ticks;
        logic [CNT_W-1:0] read_limit_ticks;
        logic [CNT_W-1:0] init_pulse_ticks;
    } cfg_t;

    typedef struct packed {
        logic              strobe_line;
        logic              autofeed_line;
        logic              init_line;
        logic [BYTE_W-1:0] drive_byte;
        logic              drive_enable;
        logic [BYTE_W-1:0] received_byte;
        logic              finished;
        logic [1:0]        outcome;
        logic              active;
    } result_t;

endpackage

// ===== rtl/pph_fsm.sv =====
// ----------------------------------------------------------------------------
// pph_fsm
// Handshake state machine: takes one item per enabled cycle, updates the port
// state and presents the result for that item combinationally.
// ----------------------------------------------------------------------------
module pph_fsm
    import pph_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   elapsed_reg, elapsed_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [BYTE_W-1:0]  in_byte_reg, in_byte_next;
    logic [CTL_W-1:0]   ctl_reg, ctl_next;
    logic               dir_reg, dir_next;

    logic [CNT_W-1:0]   elapsed_inc;
    logic [CNT_W-1:0]   limit;
    logic               moved;
    logic               is_read;
    logic               finished;
    logic [1:0]         outcome;

    // Saturating tick count
    assign elapsed_inc = (elapsed_reg == CNT_MAX) ? elapsed_reg : elapsed_reg + 24'd1;

    // Next state for one item
    always_comb begin
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        out_byte_next = out_byte_reg;
        in_byte_next  = in_byte_reg;
        ctl_next      = ctl_reg;
        dir_next      = dir_reg;
        finished      = 1'b0;
        outcome       = OUT_OK;
        moved         = 1'b0;
        is_read       = 1'b0;
        limit         = '0;

        if (item.op != OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                finished = 1'b1;
                outcome  = OUT_REJECTED;
            end else if (item.op == OP_WRITE) begin
                if (item.new_transfer) begin
                    elapsed_next = '0;
                end
                out_byte_next = item.send_byte;
                dir_next      = 1'b1;
                phase_next    = PH_W_FREE;
            end else if (item.op == OP_READ) begin
                if (item.new_transfer) begin
                    elapsed_next = '0;
                end
                dir_next   = 1'b0;
                phase_next = PH_R_FREE;
            end else begin
                ctl_next     = '0;
                ctl_next[CTL_INIT] = 1'b1;
                elapsed_next = '0;
                phase_next   = PH_RST_HOLD;
            end
        end else if (phase_reg != PH_IDLE) begin
            elapsed_next = elapsed_inc;
            case (phase_reg)
                PH_W_FREE: begin
                    if (!item.busy_seen) begin
                        ctl_next[CTL_STROBE] = 1'b1;
                        phase_next = PH_W_BUSY;
                        moved      = 1'b1;
                    end
                end
                PH_W_BUSY: begin
                    if (item.busy_seen) begin
                        ctl_next[CTL_STROBE] = 1'b0;
                        phase_next = PH_W_DONE;
                        moved      = 1'b1;
                    end
                end
                PH_W_DONE: begin
                    if (!item.busy_seen && !item.ack_seen) begin
                        phase_next = PH_IDLE;
                        finished   = 1'b1;
                        moved      = 1'b1;
                    end
                end
                PH_R_FREE: begin
                    is_read = 1'b1;
                    if (!item.busy_seen) begin
                        ctl_next[CTL_AUTOFD] = 1'b1;
                        phase_next = PH_R_ACK;
                        moved      = 1'b1;
                    end
                end
                PH_R_ACK: begin
                    is_read = 1'b1;
                    if (item.ack_seen) begin
                        in_byte_next         = item.port_lines;
                        ctl_next[CTL_AUTOFD] = 1'b0;
                        ctl_next[CTL_STROBE] = 1'b1;
                        phase_next = PH_R_REL;
                        moved      = 1'b1;
                    end
                end
                PH_R_REL: begin
                    is_read = 1'b1;
                    if (!item.ack_seen) begin
                        ctl_next[CTL_STROBE] = 1'b0;
                        dir_next   = 1'b1;
                        phase_next = PH_IDLE;
                        finished   = 1'b1;
                        moved      = 1'b1;
                    end
                end
                PH_RST_HOLD: begin
                    moved = 1'b1;
                    if (elapsed_inc >= cfg.init_pulse_ticks) begin
                        ctl_next[CTL_INIT] = 1'b0;
                        elapsed_next = '0;
                        phase_next   = PH_RST_SETTLE;
                    end
                end
                PH_RST_SETTLE: begin
                    moved = 1'b1;
                    if (elapsed_inc >= cfg.init_pulse_ticks) begin
                        elapsed_next = '0;
                        phase_next   = PH_IDLE;
                        finished     = 1'b1;
                    end
                end
                default: begin
                    // Unused phase codes fall back to idle
                    moved      = 1'b1;
                    ctl_next   = '0;
                    dir_next   = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase

            // Abort a stalled transfer once its nonzero limit is reached
            limit = is_read ? cfg.read_limit_ticks : cfg.write_limit_ticks;
            if (!moved && (limit != '0) && (elapsed_inc >= limit)) begin
                ctl_next   = '0;
                dir_next   = 1'b1;
                phase_next = PH_IDLE;
                finished   = 1'b1;
                outcome    = is_read ? OUT_RD_TMO : OUT_WR_TMO;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            elapsed_reg  <= '0;
            out_byte_reg <= '0;
            in_byte_reg  <= '0;
            ctl_reg      <= '0;
            dir_reg      <= 1'b1;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            out_byte_reg <= out_byte_next;
            in_byte_reg  <= in_byte_next;
            ctl_reg      <= ctl_next;
            dir_reg      <= dir_next;
        end
    end

    // Result shows the state after the item
    always_comb begin
        result.strobe_line   = ctl_next[CTL_STROBE];
        result.autofeed_line = ctl_next[CTL_AUTOFD];
        result.init_line     = ctl_next[CTL_INIT];
        result.drive_byte    = out_byte_next;
        result.drive_enable  = dir_next;
        result.received_byte = in_byte_next;
        result.finished      = finished;
        result.outcome       = outcome;
        result.active        = (phase_next != PH_IDLE);
    end

endmodule

// ===== rtl/parallel_port_byte_handshake_core.sv =====
// ----------------------------------------------------------------------------
// parallel_port_byte_handshake_core
// Host side of a printer parallel port: write, read and reset requests plus
// status ticks, one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | request or tick with status sample (tuser = op)
//  m_       | out       | control lines, data bytes, completion status
//  cfg_     | in        | write_limit, read_limit, init_pulse (24 bits each)
//
// One item per cycle sustained while m_tready is high; an accepted item passes
// the input register, then the FSM step, then the result register before its
// result item is offered. Reset is synchronous active low and leaves
// the port idle with the data lines driven. A stalled result holds the input
// register; s_tready drops only when both stages are full and m_tready is low.
// ----------------------------------------------------------------------------
module parallel_port_byte_handshake_core
    import pph_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // send_byte[7:0], new_transfer[8], busy_seen[9],
                                  // ack_seen[10], port_lines[18:11], zero[23:19]
    input  logic [1:0]  s_tuser,  // op[1:0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // strobe_line[0], autofeed_line[1], init_line[2],
                                  // drive_byte[10:3], drive_enable[11],
                                  // received_byte[19:12], finished[20],
                                  // outcome[22:21], active[23]
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    cfg_t    cfg_reg;
    result_t step_result;
    logic    step_en;

    // Advance the held item when the result slot is free
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op           <= s_tuser;
            in_item_reg.send_byte    <= s_tdata[7:0];
            in_item_reg.new_transfer <= s_tdata[8];
            in_item_reg.busy_seen    <= s_tdata[9];
            in_item_reg.ack_seen     <= s_tdata[10];
            in_item_reg.port_lines   <= s_tdata[18:11];
        end
    end

    // Configuration registers; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.write_limit_ticks <= '0;
            cfg_reg.read_limit_ticks  <= '0;
            cfg_reg.init_pulse_ticks  <= INIT_PULSE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WRITE_LIMIT: cfg_reg.write_limit_ticks <= cfg_wdata;
                CFG_READ_LIMIT:  cfg_reg.read_limit_ticks  <= cfg_wdata;
                CFG_INIT_PULSE:  cfg_reg.init_pulse_ticks  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pph_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.active,
                       out_result_reg.outcome,
                       out_result_reg.finished,
                       out_result_reg.received_byte,
                       out_result_reg.drive_enable,
                       out_result_reg.drive_byte,
                       out_result_reg.init_line,
                       out_result_reg.autofeed_line,
                       out_result_reg.strobe_line};

endmodule
